[rtl/gnms_pkg.sv]
// Shared constants, types and direction codes for the gradient non-maximum suppression block.
// Has no dependencies; every other file in rtl imports it.
package gnms_pkg;

   localparam int IMAGE_WIDTH  = 256;
   localparam int IMAGE_HEIGHT = 256;
   localparam int COL_BITS     = $clog2(IMAGE_WIDTH);
   localparam int ROW_BITS     = $clog2(IMAGE_HEIGHT);
   localparam int GRAD_BITS    = 16;
   localparam int MAG_BITS     = 16;
   localparam int BORDER_BITS  = 7;
   localparam int COORD_BITS   = 8;
   localparam int MAX_DIM      = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
   localparam int CMP_BITS     = $clog2(MAX_DIM + (1 << BORDER_BITS)) + 1;

   localparam logic [17:0] TAN_LO = 18'd27145;
   localparam logic [17:0] TAN_HI = 18'd158217;

   localparam logic [BORDER_BITS-1:0] BORDER_RESET = 7'd1;

   typedef logic [1:0] dir_type;
   localparam dir_type DIR_H = 2'd0;
   localparam dir_type DIR_D = 2'd1;
   localparam dir_type DIR_A = 2'd2;
   localparam dir_type DIR_V = 2'd3;

   typedef logic [MAG_BITS-1:0] mag_type;

   typedef struct packed {
      dir_type dir;
      mag_type older;
      mag_type prev;
   } line_entry_type;

endpackage

[rtl/gnms_dir_bin.sv]
// Bins a gradient vector into one of four directions using two constant multiplies.
// Depends on gnms_pkg.
module gnms_dir_bin
   import gnms_pkg::*;
(
   input  logic signed [GRAD_BITS-1:0] grad_x,
   input  logic signed [GRAD_BITS-1:0] grad_y,
   output dir_type                     dir
);

   logic signed [GRAD_BITS:0]   gx_ext;
   logic signed [GRAD_BITS:0]   gy_ext;
   logic signed [GRAD_BITS:0]   gy_signed;
   logic        [GRAD_BITS:0]   abs_x;
   logic        [34:0]          prod_lo;
   logic        [34:0]          prod_hi;
   logic signed [35:0]          s_val;
   logic signed [35:0]          t_lo;
   logic signed [35:0]          t_hi;

   always_comb begin
      gx_ext    = {grad_x[GRAD_BITS-1], grad_x};
      gy_ext    = {grad_y[GRAD_BITS-1], grad_y};
      abs_x     = grad_x[GRAD_BITS-1] ? unsigned'(-gx_ext) : unsigned'(gx_ext);
      gy_signed = grad_x[GRAD_BITS-1] ? -gy_ext : gy_ext;
      prod_lo   = 35'(TAN_LO) * 35'(abs_x);
      prod_hi   = 35'(TAN_HI) * 35'(abs_x);
      s_val     = {{3{gy_signed[GRAD_BITS]}}, gy_signed, 16'h0000};
      t_lo      = signed'({1'b0, prod_lo});
      t_hi      = signed'({1'b0, prod_hi});
      priority if (grad_x == '0) begin
         dir = (grad_y == '0) ? DIR_H : DIR_V;
      end else if (s_val <= t_lo && s_val > -t_lo) begin
         dir = DIR_H;
      end else if (s_val > t_lo && s_val <= t_hi) begin
         dir = DIR_D;
      end else if (s_val <= -t_lo && s_val > -t_hi) begin
         dir = DIR_A;
      end else begin
         dir = DIR_V;
      end
   end

endmodule

[rtl/gnms_line_store.sv]
// Line store holding the previous and older row magnitudes and the previous row direction.
// Registered read with write-to-read forwarding. Depends on gnms_pkg.
module gnms_line_store
   import gnms_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [COL_BITS-1:0]  wr_addr,
   input  line_entry_type       wr_data,
   input  logic                 rd_en,
   input  logic [COL_BITS-1:0]  rd_addr,
   output line_entry_type       rd_data
);

   line_entry_type mem [IMAGE_WIDTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gnms_window.sv]
// 3x3 magnitude window and two-entry direction window with the peak comparison.
// Depends on gnms_pkg.
module gnms_window
   import gnms_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  mag_type        mag_new,
   input  line_entry_type line_rd,
   output mag_type        centre_mag,
   output logic           local_max
);

   mag_type mag_window_ff [3][3];
   mag_type mag_window_in [3][3];
   dir_type dir_window_ff [2];
   dir_type dir_window_in [2];
   mag_type n1;
   mag_type n2;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag_window_in[k][0] = mag_window_ff[k][1];
         mag_window_in[k][1] = mag_window_ff[k][2];
      end
      mag_window_in[0][2] = line_rd.older;
      mag_window_in[1][2] = line_rd.prev;
      mag_window_in[2][2] = mag_new;
      dir_window_in[1]    = dir_window_ff[0];
      dir_window_in[0]    = line_rd.dir;
   end

   always_comb begin
      unique case (dir_window_in[1])
         DIR_H: begin
            n1 = mag_window_in[1][0];
            n2 = mag_window_in[1][2];
         end
         DIR_D: begin
            n1 = mag_window_in[0][0];
            n2 = mag_window_in[2][2];
         end
         DIR_A: begin
            n1 = mag_window_in[2][0];
            n2 = mag_window_in[0][2];
         end
         default: begin
            n1 = mag_window_in[0][1];
            n2 = mag_window_in[2][1];
         end
      endcase
      centre_mag = mag_window_in[1][1];
      local_max  = (centre_mag > n1) && (centre_mag > n2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               mag_window_ff[k][j] <= '0;
            end
         end
         dir_window_ff[0] <= DIR_H;
         dir_window_ff[1] <= DIR_H;
      end else if (advance) begin
         mag_window_ff    <= mag_window_in;
         dir_window_ff[0] <= dir_window_in[0];
         dir_window_ff[1] <= dir_window_in[1];
      end
   end

endmodule

[rtl/gradient_non_maximum_suppression.sv]
// Gradient non-maximum suppression over a raster pixel stream; top level.
// An accepted request is held in the input register; its result is registered in the output
// register behind rsp_valid. Throughput is one pixel per cycle, no gaps, while rsp_stall stays low.
// A result held by rsp_stall keeps the input register full and stalls requests until it leaves.
// Synchronous reset clears counters, window, valids and sets border_width to 1; line
// contents are not cleared. Uses gnms_pkg, gnms_dir_bin, gnms_line_store and gnms_window.
module gradient_non_maximum_suppression
   import gnms_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [GRAD_BITS-1:0] req_gradient_x,
   input  logic signed [GRAD_BITS-1:0] req_gradient_y,
   input  logic [MAG_BITS-1:0]         req_magnitude,
   input  logic                        req_frame_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [COORD_BITS-1:0]       rsp_centre_row,
   output logic [COORD_BITS-1:0]       rsp_centre_col,
   output logic [MAG_BITS-1:0]         rsp_centre_magnitude,
   output logic                        rsp_is_peak,
   input  logic                        csr_write_enable,
   input  logic [BORDER_BITS-1:0]      csr_write_data
);

   logic [BORDER_BITS-1:0]      border_width_ff;
   logic [ROW_BITS-1:0]         row_count_ff;
   logic [COL_BITS-1:0]         col_count_ff;
   logic [ROW_BITS-1:0]         pix_row;
   logic [COL_BITS-1:0]         pix_col;
   logic                        req_accept;
   logic                        rsp_free;
   logic                        s1_move;
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic signed [GRAD_BITS-1:0] s1_gx_ff;
   logic signed [GRAD_BITS-1:0] s1_gy_ff;
   mag_type                     s1_mag_ff;
   logic [ROW_BITS-1:0]         s1_row_ff;
   logic [COL_BITS-1:0]         s1_col_ff;
   dir_type                     s1_dir;
   line_entry_type              line_rd;
   line_entry_type              line_wr;
   mag_type                     centre_mag;
   logic                        local_max;
   logic                        produce;
   logic                        in_band;
   logic [CMP_BITS-1:0]         cr;
   logic [CMP_BITS-1:0]         cc;
   logic [CMP_BITS-1:0]         bw;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [COORD_BITS-1:0]       rsp_row_ff;
   logic [COORD_BITS-1:0]       rsp_col_ff;
   mag_type                     rsp_mag_ff;
   logic                        rsp_peak_ff;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && rsp_free;
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign pix_row    = req_frame_start ? '0 : row_count_ff;
   assign pix_col    = req_frame_start ? '0 : col_count_ff;

   gnms_dir_bin u_dir_bin (
      .grad_x (s1_gx_ff),
      .grad_y (s1_gy_ff),
      .dir    (s1_dir)
   );

   assign line_wr.dir   = s1_dir;
   assign line_wr.older = line_rd.prev;
   assign line_wr.prev  = s1_mag_ff;

   gnms_line_store u_line_store (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_en   (req_accept),
      .rd_addr (pix_col),
      .rd_data (line_rd)
   );

   gnms_window u_window (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_move),
      .mag_new    (s1_mag_ff),
      .line_rd    (line_rd),
      .centre_mag (centre_mag),
      .local_max  (local_max)
   );

   always_comb begin
      produce = (s1_row_ff >= ROW_BITS'(2)) && (s1_col_ff >= COL_BITS'(2));
      cr      = CMP_BITS'(s1_row_ff) - CMP_BITS'(1);
      cc      = CMP_BITS'(s1_col_ff) - CMP_BITS'(1);
      bw      = CMP_BITS'(border_width_ff);
      in_band = (cr >= bw) && ((cr + bw) < CMP_BITS'(IMAGE_HEIGHT))
                && (cc >= bw) && ((cc + bw) < CMP_BITS'(IMAGE_WIDTH));
      s1_valid_in  = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = rsp_free ? (s1_move && produce) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         border_width_ff <= BORDER_RESET;
         row_count_ff    <= '0;
         col_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            border_width_ff <= csr_write_data;
         end
         if (req_accept) begin
            if (pix_col == COL_BITS'(IMAGE_WIDTH - 1)) begin
               col_count_ff <= '0;
               row_count_ff <= (pix_row == ROW_BITS'(IMAGE_HEIGHT - 1)) ?
                               '0 : pix_row + ROW_BITS'(1);
            end else begin
               col_count_ff <= pix_col + COL_BITS'(1);
               row_count_ff <= pix_row;
            end
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_gx_ff  <= req_gradient_x;
         s1_gy_ff  <= req_gradient_y;
         s1_mag_ff <= req_magnitude;
         s1_row_ff <= pix_row;
         s1_col_ff <= pix_col;
      end
      if (s1_move && produce) begin
         rsp_row_ff  <= cr[COORD_BITS-1:0];
         rsp_col_ff  <= cc[COORD_BITS-1:0];
         rsp_mag_ff  <= centre_mag;
         rsp_peak_ff <= in_band && local_max;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_centre_row       = rsp_row_ff;
   assign rsp_centre_col       = rsp_col_ff;
   assign rsp_centre_magnitude = rsp_mag_ff;
   assign rsp_is_peak          = rsp_peak_ff;

   // A pixel leaving the input register with a full window must produce a result.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (s1_move && produce) |=> rsp_valid_ff)
      else $error("complete window did not produce a result");

   // The input side is held back only by a full input register behind a held output register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled without a blocked pipeline");

   // A peak is strictly greater than a neighbor, so it cannot have zero magnitude.
   a_peak_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_peak_ff) |-> (rsp_mag_ff != '0))
      else $error("peak reported with zero magnitude");

   // A held input register keeps its request until the output side frees up.
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("input register lost a request while blocked");

endmodule
